// File: sv/dma_descriptor_ring_builder_unit_defines.svh
// ----------------------------------------------------------------------------
// DMA descriptor ring builder: assertion macros
// Shared concurrent assertion forms; clk and rst_n are taken from the scope.
// ----------------------------------------------------------------------------
`ifndef DMA_DESCRIPTOR_RING_BUILDER_UNIT_DEFINES_SVH
`define DMA_DESCRIPTOR_RING_BUILDER_UNIT_DEFINES_SVH

// same-cycle implication
`define DBRB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbrb: same-cycle check failed");

// next-cycle implication
`define DBRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbrb: next-cycle check failed");

`endif

// File: sv/dbrb_pkg.sv
// ----------------------------------------------------------------------------
// DMA descriptor ring builder package
// Payload types, codes, sizing constants and address helper.
// ----------------------------------------------------------------------------
package dbrb_pkg;

  localparam int unsigned RING_ENTRIES = 256;
  localparam int unsigned MAX_CHUNKS   = 16;
  localparam int unsigned MAX_SIZE     = MAX_CHUNKS * 65536;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [9:0]  RING_N     = 10'(RING_ENTRIES);
  localparam logic [7:0]  SLOT_LAST  = 8'(RING_ENTRIES - 1);
  localparam logic [10:0] LEN_CAP    = 11'd1024;
  localparam logic [15:0] LEN_CAP_U  = 16'd1024;

  localparam logic [1:0] OUTCOME_OK      = 2'd0;
  localparam logic [1:0] OUTCOME_BUSY    = 2'd1;
  localparam logic [1:0] OUTCOME_INVALID = 2'd2;

  localparam logic [1:0] KIND_COPY   = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic REG_RING_READY  = 1'b0;
  localparam logic REG_SYSTEM_BASE = 1'b1;

  typedef struct packed {
    logic [39:0] src_addr;
    logic        src_local;
    logic [39:0] dst_addr;
    logic        dst_local;
    logic [20:0] size_bytes;
    logic        want_interrupt;
    logic        want_notify;
    logic [39:0] notify_addr;
    logic        notify_local;
    logic [63:0] notify_data;
    logic [7:0]  ring_tail;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [1:0]  desc_kind;
    logic [39:0] desc_src;
    logic [39:0] desc_dst;
    logic [10:0] desc_length;
    logic        desc_interrupt;
    logic [63:0] desc_data;
    logic [7:0]  desc_slot;
    logic [7:0]  head_after;
    logic        last;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  outcome;
    logic        no_desc;
    logic [5:0]  nchunks;
    logic        status;
    logic        intr;
    logic [39:0] src;
    logic [39:0] dst;
    logic [39:0] ntf_addr;
    logic [63:0] ntf_data;
    logic [15:0] units;
    logic [7:0]  slot;
    logic [7:0]  head_after;
  } cmd_t;

  function automatic logic [39:0] host_addr(input logic [39:0] addr,
                                            input logic        is_local,
                                            input logic [39:0] base);
    host_addr = is_local ? addr : addr + base;
  endfunction

endpackage

// File: sv/dbrb_queue.sv
// ----------------------------------------------------------------------------
// DMA descriptor ring builder command queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module dbrb_queue import dbrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head_cmd
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/dbrb_front.sv
// ----------------------------------------------------------------------------
// DMA descriptor ring builder front end
// Holds configuration and ring head, checks a request and classifies it.
// ----------------------------------------------------------------------------
module dbrb_front import dbrb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [39:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic        ring_ready_r;
  logic [39:0] system_base_r;
  logic [7:0]  head_r, head_nxt;

  logic [21:0] chunk_sum;
  logic [21:0] unit_sum;
  logic [5:0]  chunks;
  logic        status;
  logic [6:0]  ndesc;
  logic [9:0]  h10, t10, n10, wrap_sum;
  logic        too_big;
  logic        room;
  logic [1:0]  outcome;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    chunk_sum = {1'b0, in_data.size_bytes} + 22'd65535;
    unit_sum  = {1'b0, in_data.size_bytes} + 22'd63;
    chunks    = chunk_sum[21:16];
    status    = in_data.want_interrupt || in_data.want_notify;
    ndesc     = {1'b0, chunks} + 7'(status);
    too_big   = 32'(in_data.size_bytes) > MAX_SIZE;
    h10       = {2'b00, head_r};
    t10       = {2'b00, in_data.ring_tail};
    n10       = 10'(ndesc);
    priority if (h10 == t10) begin
      room = n10 < RING_N;
    end else if (h10 < t10) begin
      room = (t10 - h10) > n10;
    end else begin
      room = (RING_N - h10 + t10) > n10;
    end
    priority if (!ring_ready_r || too_big) begin
      outcome = OUTCOME_INVALID;
    end else if (!room) begin
      outcome = OUTCOME_BUSY;
    end else begin
      outcome = OUTCOME_OK;
    end
    wrap_sum = h10 + n10;
    if (wrap_sum >= RING_N) begin
      wrap_sum = wrap_sum - RING_N;
    end
    head_nxt = head_r;
    if (accept && outcome == OUTCOME_OK) begin
      head_nxt = wrap_sum[7:0];
    end

    q_cmd.outcome    = outcome;
    q_cmd.no_desc    = (outcome != OUTCOME_OK) || (ndesc == 7'd0);
    q_cmd.nchunks    = chunks;
    q_cmd.status     = status;
    q_cmd.intr       = in_data.want_interrupt;
    q_cmd.src        = host_addr(in_data.src_addr, in_data.src_local, system_base_r);
    q_cmd.dst        = host_addr(in_data.dst_addr, in_data.dst_local, system_base_r);
    q_cmd.ntf_addr   = host_addr(in_data.notify_addr, in_data.notify_local,
                                 system_base_r);
    q_cmd.ntf_data   = in_data.notify_data;
    q_cmd.units      = unit_sum[21:6];
    q_cmd.slot       = head_r;
    q_cmd.head_after = (outcome == OUTCOME_OK) ? wrap_sum[7:0] : head_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_ready_r  <= 1'b0;
      system_base_r <= '0;
      head_r        <= '0;
    end else begin
      head_r <= head_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_RING_READY:  ring_ready_r  <= cfg_data[0];
          REG_SYSTEM_BASE: system_base_r <= cfg_data;
          default:         ring_ready_r  <= ring_ready_r;
        endcase
      end
    end
  end

endmodule

// File: sv/dbrb_back.sv
// ----------------------------------------------------------------------------
// DMA descriptor ring builder back end
// Walks a classified request and emits one descriptor result per transfer.
// ----------------------------------------------------------------------------
module dbrb_back import dbrb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] units_r, units_nxt;
  logic [7:0]  slot_r, slot_nxt;

  logic        emit;
  logic        first;
  logic [15:0] rem;
  logic [7:0]  slot;
  logic        is_copy;
  logic        last_c;
  logic [39:0] offset;
  out_item_t   item;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign emit      = q_not_empty && (!out_valid_r || out_ready);
  assign q_pop     = emit && last_c;

  always_comb begin
    first   = (cnt_r == '0);
    rem     = first ? q_cmd.units : units_r;
    slot    = first ? q_cmd.slot : slot_r;
    is_copy = !q_cmd.no_desc && (cnt_r < q_cmd.nchunks);
    offset  = 40'(cnt_r) << 16;
    last_c  = q_cmd.no_desc || !is_copy ||
              ((cnt_r + 6'd1 == q_cmd.nchunks) && !q_cmd.status);

    item                = '0;
    item.outcome        = q_cmd.outcome;
    item.head_after     = q_cmd.head_after;
    item.last           = last_c;
    priority if (q_cmd.no_desc) begin
      item.desc_kind = KIND_NONE;
    end else if (is_copy) begin
      item.desc_kind   = KIND_COPY;
      item.desc_src    = q_cmd.src + offset;
      item.desc_dst    = q_cmd.dst + offset;
      item.desc_length = (rem > LEN_CAP_U) ? LEN_CAP : rem[10:0];
      item.desc_slot   = slot;
    end else begin
      item.desc_kind      = KIND_STATUS;
      item.desc_interrupt = q_cmd.intr;
      item.desc_dst       = q_cmd.intr ? '0 : q_cmd.ntf_addr;
      item.desc_data      = q_cmd.intr ? '0 : q_cmd.ntf_data;
      item.desc_slot      = slot;
    end

    cnt_nxt   = cnt_r;
    units_nxt = units_r;
    slot_nxt  = slot_r;
    if (emit) begin
      if (last_c) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt   = cnt_r + 6'd1;
        units_nxt = rem - LEN_CAP_U;
        slot_nxt  = (slot == SLOT_LAST) ? '0 : slot + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    units_r <= units_nxt;
    slot_r  <= slot_nxt;
    if (emit) begin
      out_data_r <= item;
    end
  end

endmodule

// File: sv/dma_descriptor_ring_builder_unit.sv
// ----------------------------------------------------------------------------
// DMA descriptor ring builder
// Splits copy requests into 64 KiB ring descriptors plus an optional status.
// ----------------------------------------------------------------------------
// A request yields one result per descriptor (its chunks, then the status
// descriptor if asked for), or one kind-none result when it is invalid, busy
// or has nothing to write; the last result carries last=1 and every result of
// a request carries the head after that request. The back end emits one result
// per cycle when not stalled; a request yields max(1, chunks + status) results,
// at most 17. The front end checks room and advances the head in the cycle the
// request is taken, and a two-entry queue lets it take the next requests while
// the back end is still emitting. Configuration writes are always accepted.
module dma_descriptor_ring_builder_unit import dbrb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [39:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_in_cmd;
  cmd_t q_head_cmd;

  assign cfg_ready = 1'b1;

  dbrb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd)
  );

  dbrb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (q_head_cmd)
  );

  dbrb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_cmd       (q_head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// File: sv/dbrb_checker.sv
// ----------------------------------------------------------------------------
// DMA descriptor ring builder port checker
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`include "dma_descriptor_ring_builder_unit_defines.svh"

module dbrb_checker import dbrb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `DBRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `DBRB_ASSERT_SAME(a_none_last, out_valid && out_data.desc_kind == KIND_NONE, out_data.last)
  `DBRB_ASSERT_SAME(a_fail_none, out_valid && out_data.outcome != OUTCOME_OK, out_data.desc_kind == KIND_NONE)
  `DBRB_ASSERT_SAME(a_copy_len, out_valid && out_data.desc_kind == KIND_COPY, out_data.desc_length != 11'd0 && out_data.desc_length <= LEN_CAP)

endmodule

bind dma_descriptor_ring_builder_unit dbrb_checker u_dbrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: bench/tb_dma_descriptor_ring_builder_unit.sv
// ----------------------------------------------------------------------------
// DMA descriptor ring builder testbench
// Drives copy requests and register writes through valid/ready channels with
// random gaps and output stalls. A tracker class predicts every descriptor,
// the ring head and the outcome, and checks each result transfer in order.
// ----------------------------------------------------------------------------
module tb_dma_descriptor_ring_builder_unit import dbrb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  class desc_ring_tracker;
    bit          ring_ready;
    logic [39:0] system_base;
    int unsigned ring_head;
    out_item_t   pending_descs[$];
    int unsigned errors;

    function void set_reg(logic idx, logic [39:0] val);
      if (idx == REG_RING_READY) ring_ready = val[0];
      else system_base = val;
    endfunction

    function logic [39:0] rebase(logic [39:0] addr, logic is_local);
      return is_local ? addr : addr + system_base;
    endfunction

    function bit room_for(int unsigned tail, int unsigned n);
      if (ring_head == tail) return n < RING_ENTRIES;
      if (ring_head < tail) return (tail - ring_head) > n;
      return (RING_ENTRIES - ring_head + tail) > n;
    endfunction

    function out_item_t blank(logic [1:0] outcome, logic [1:0] kind);
      out_item_t d;
      d = '0;
      d.outcome = outcome;
      d.desc_kind = kind;
      return d;
    endfunction

    function void take_request(in_item_t r);
      out_item_t   batch[$];
      out_item_t   d;
      bit          status;
      int unsigned size, nchunks, ndesc, units;
      logic [39:0] src, dst;
      size = 32'(r.size_bytes);
      status = r.want_interrupt || r.want_notify;
      if (!ring_ready || size > MAX_SIZE) begin
        batch.push_back(blank(OUTCOME_INVALID, KIND_NONE));
      end else begin
        nchunks = (size + 65535) >> 16;
        ndesc = nchunks + 32'(status);
        if (!room_for(32'(r.ring_tail), ndesc)) begin
          batch.push_back(blank(OUTCOME_BUSY, KIND_NONE));
        end else if (ndesc == 0) begin
          batch.push_back(blank(OUTCOME_OK, KIND_NONE));
        end else begin
          units = (size + 63) >> 6;
          src = rebase(r.src_addr, r.src_local);
          dst = rebase(r.dst_addr, r.dst_local);
          for (int unsigned i = 0; i < nchunks; i++) begin
            d = blank(OUTCOME_OK, KIND_COPY);
            d.desc_src = src + (40'(i) << 16);
            d.desc_dst = dst + (40'(i) << 16);
            d.desc_length = 11'(units > 1024 ? 1024 : units);
            d.desc_slot = 8'(ring_head);
            if (units > 1024) units -= 1024;
            batch.push_back(d);
            ring_head = (ring_head + 1) % RING_ENTRIES;
          end
          if (status) begin
            d = blank(OUTCOME_OK, KIND_STATUS);
            d.desc_slot = 8'(ring_head);
            // interrupt takes priority over notify
            if (r.want_interrupt) begin
              d.desc_interrupt = 1'b1;
            end else begin
              d.desc_dst = rebase(r.notify_addr, r.notify_local);
              d.desc_data = r.notify_data;
            end
            batch.push_back(d);
            ring_head = (ring_head + 1) % RING_ENTRIES;
          end
        end
      end
      foreach (batch[k]) begin
        batch[k].head_after = 8'(ring_head);
        batch[k].last = (k == batch.size() - 1);
        pending_descs.push_back(batch[k]);
      end
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_descriptor(out_item_t got);
      out_item_t want;
      if (pending_descs.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, actual %h", $time, got);
        return;
      end
      want = pending_descs.pop_front();
      compare("outcome", 64'(want.outcome), 64'(got.outcome));
      compare("desc_kind", 64'(want.desc_kind), 64'(got.desc_kind));
      compare("desc_src", 64'(want.desc_src), 64'(got.desc_src));
      compare("desc_dst", 64'(want.desc_dst), 64'(got.desc_dst));
      compare("desc_length", 64'(want.desc_length), 64'(got.desc_length));
      compare("desc_interrupt", 64'(want.desc_interrupt), 64'(got.desc_interrupt));
      compare("desc_data", want.desc_data, got.desc_data);
      compare("desc_slot", 64'(want.desc_slot), 64'(got.desc_slot));
      compare("head_after", 64'(want.head_after), 64'(got.head_after));
      compare("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_RING_READY;
  logic [39:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  desc_ring_tracker tracker = new();
  bit          steady = 1'b0;
  int unsigned stall_left = 0;

  dma_descriptor_ring_builder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [39:0] rand40();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '1;
    if (r < 15) return '0;
    return 40'({$urandom(), $urandom()});
  endfunction

  function automatic in_item_t random_request();
    in_item_t    r;
    int unsigned pick, size, n;
    r.src_addr = rand40();
    r.src_local = 1'($urandom_range(0, 1));
    r.dst_addr = rand40();
    r.dst_local = 1'($urandom_range(0, 1));
    r.want_interrupt = 1'($urandom_range(0, 1));
    r.want_notify = 1'($urandom_range(0, 1));
    r.notify_addr = rand40();
    r.notify_local = 1'($urandom_range(0, 1));
    r.notify_data = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    if (pick < 5) size = 0;
    else if (pick < 35) size = $urandom_range(1, 4096);
    else if (pick < 55) size = $urandom_range(1, 3 * 65536);
    else if (pick < 75) size = $urandom_range(1, MAX_SIZE);
    else if (pick < 85) size = 65536 * $urandom_range(1, 16) + $urandom_range(0, 2) - 1;
    else if (pick < 92) size = MAX_SIZE;
    else size = $urandom_range(MAX_SIZE + 1, (1 << 21) - 1);
    r.size_bytes = 21'(size);
    n = ((size + 65535) >> 16) + 32'(r.want_interrupt || r.want_notify);
    pick = $urandom_range(0, 99);
    if (pick < 40 || n == 0) r.ring_tail = 8'(tracker.ring_head);
    else if (pick < 80) r.ring_tail = 8'(tracker.ring_head + n + 1 + $urandom_range(0, 50));
    else if (pick < 90) r.ring_tail = 8'(tracker.ring_head + $urandom_range(1, n));
    else r.ring_tail = 8'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic send_request(in_item_t r);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_request(r);
  endtask

  task automatic push_request(in_item_t r);
    int unsigned gap;
    send_request(r);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drive_case(int unsigned size, bit intr, bit ntf, int unsigned tail_ofs);
    in_item_t r;
    r = random_request();
    r.size_bytes = 21'(size);
    r.want_interrupt = intr;
    r.want_notify = ntf;
    r.ring_tail = 8'(tracker.ring_head + tail_ofs);
    push_request(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_descs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [39:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      steady = (i % 64) < 10;
      push_request(random_request());
    end
    steady = 1'b0;
  endtask

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_descriptor(out_data);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!steady) stall_left = pick_gap();
    end
  end

  initial begin
    in_item_t r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ring not set up yet
    drive_case(4096, 1, 0, 0);
    wait_idle();
    write_reg(REG_RING_READY, 40'd1);
    write_reg(REG_SYSTEM_BASE, 40'd0);

    drive_case(0, 0, 0, 0);
    drive_case(0, 1, 0, 0);
    drive_case(0, 0, 1, 0);
    drive_case(1, 0, 0, 0);
    drive_case(64, 0, 0, 2);
    drive_case(65, 1, 1, 0);
    drive_case(65535, 0, 1, 0);
    drive_case(65536, 0, 0, 0);
    drive_case(65537, 1, 0, 0);
    drive_case(MAX_SIZE, 1, 1, 0);
    drive_case(MAX_SIZE + 1, 0, 0, 0);
    drive_case((1 << 21) - 1, 1, 1, 0);
    drive_case(3 * 65536, 0, 0, 3);
    drive_case(3 * 65536, 0, 0, 4);
    drive_case(1, 1, 0, 1);

    r = '1;
    r.size_bytes = 21'(2 * 65536);
    r.want_interrupt = 1'b0;
    r.notify_local = 1'b0;
    r.ring_tail = 8'hFF;
    push_request(r);
    r = '0;
    r.size_bytes = 21'(3 * 65536);
    push_request(r);

    wait_idle();
    write_reg(REG_SYSTEM_BASE, '1);
    r = random_request();
    r.src_local = 1'b0;
    r.dst_local = 1'b0;
    r.notify_local = 1'b0;
    r.want_interrupt = 1'b0;
    r.want_notify = 1'b1;
    r.size_bytes = 21'(4 * 65536);
    r.ring_tail = 8'(tracker.ring_head);
    push_request(r);

    run_random(150);
    wait_idle();
    write_reg(REG_SYSTEM_BASE, '0);
    run_random(150);
    wait_idle();
    write_reg(REG_RING_READY, 40'd0);
    write_reg(REG_SYSTEM_BASE, rand40());
    run_random(12);
    wait_idle();
    write_reg(REG_RING_READY, 40'd1);
    run_random(170);

    wait_idle();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_descs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: dma_descriptor_ring_builder_unit.f
+incdir+sv
sv/dbrb_pkg.sv
sv/dbrb_queue.sv
sv/dbrb_front.sv
sv/dbrb_back.sv
sv/dma_descriptor_ring_builder_unit.sv
sv/dbrb_checker.sv
bench/tb_dma_descriptor_ring_builder_unit.sv
